// File: hw/rtl/jfp_pkg.sv
// jfp_pkg: shared types, character constants and helpers of the flat json parser
// no dependencies; used by jfp_out_if and by every parser module
package jfp_pkg;

    // result kinds as seen on the output channel
    typedef enum logic [2:0] {
        KIND_KEY_BYTE = 3'd0,
        KIND_VAL_BYTE = 3'd1,
        KIND_KEY_END  = 3'd2,
        KIND_PAIR_END = 3'd3,
        KIND_DONE     = 3'd4,
        KIND_ERROR    = 3'd5
    } t_kind;

    // parse modes of the front end
    typedef enum logic [3:0] {
        MODE_OPEN     = 4'd0,
        MODE_FIRST    = 4'd1,
        MODE_KEYQ     = 4'd2,
        MODE_KEY      = 4'd3,
        MODE_KEY_ESC  = 4'd4,
        MODE_COLON    = 4'd5,
        MODE_VALUE    = 4'd6,
        MODE_VSTR     = 4'd7,
        MODE_VSTR_ESC = 4'd8,
        MODE_VRAW     = 4'd9,
        MODE_AFTER    = 4'd10,
        MODE_IDLE     = 4'd11
    } t_mode;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_LIMIT   = 1'b0,
        CFG_VALUE_LIMIT = 1'b1
    } t_cfg_index;

    localparam logic [7:0] KEY_LIMIT_RESET   = 8'd31;
    localparam logic [7:0] VALUE_LIMIT_RESET = 8'd63;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    // one queued entry: a result, optionally followed by an object done
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       two;
    } t_entry;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_N:    r = CH_LF;
            CH_T:    r = CH_TAB;
            CH_R:    r = CH_CR;
            CH_B:    r = CH_BS;
            CH_F:    r = CH_FF;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/jfp_if.sv
// jfp_in_if, jfp_out_if: valid/ready channels for text bytes and parse results
// depends on jfp_pkg for the result kind type
interface jfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jfp_out_if;
    logic          valid;
    logic          ready;
    jfp_pkg::t_kind kind;
    logic [7:0]    out_byte;
    logic          last_of_run;

    modport source (output valid, output kind, output out_byte, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input last_of_run,
                    output ready);
endinterface

// File: hw/rtl/jfp_front.sv
// jfp_front: parse state machine; takes one text byte a cycle while the result queue is not full and queues its results
// depends on jfp_pkg
module jfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_cfg_we,
    input  logic [jfp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_full,
    output logic            o_push,
    output jfp_pkg::t_entry o_entry
);
    import jfp_pkg::*;

    t_mode      r_mode, n_mode;
    logic [7:0] r_kept, n_kept;
    logic [7:0] r_key_limit;
    logic [7:0] r_value_limit;
    logic       w_accept;
    logic       w_keep_key;
    logic       w_keep_val;
    logic       w_ws;
    logic [7:0] w_unesc;

    assign o_ready    = !i_full;
    assign w_accept   = i_valid && !i_full;
    assign w_keep_key = r_kept < r_key_limit;
    assign w_keep_val = r_kept < r_value_limit;
    assign w_ws       = is_ws(i_byte);
    assign w_unesc    = unescape(i_byte);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_limit   <= KEY_LIMIT_RESET;
            r_value_limit <= VALUE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_KEY_LIMIT:   r_key_limit   <= i_cfg_data;
                CFG_VALUE_LIMIT: r_value_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // mode and kept count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OPEN;
            r_kept <= 8'd0;
        end else begin
            r_mode <= n_mode;
            r_kept <= n_kept;
        end
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_kept = r_kept;
        if (w_accept) begin
            if (i_byte == CH_NUL) begin
                n_mode = MODE_OPEN;
            end else begin
                unique case (r_mode)
                    MODE_IDLE: ;
                    MODE_OPEN: begin
                        if (i_byte == CH_LBRACE) n_mode = MODE_FIRST;
                        else if (!w_ws) n_mode = MODE_IDLE;
                    end
                    MODE_FIRST, MODE_KEYQ: begin
                        if (!w_ws) begin
                            if (i_byte == CH_QUOTE) begin
                                n_mode = MODE_KEY;
                                n_kept = 8'd0;
                            end else begin
                                n_mode = MODE_IDLE;
                            end
                        end
                    end
                    MODE_KEY: begin
                        if (i_byte == CH_QUOTE) n_mode = MODE_COLON;
                        else if (i_byte == CH_BSLASH) n_mode = MODE_KEY_ESC;
                        else if (w_keep_key) n_kept = r_kept + 8'd1;
                    end
                    MODE_KEY_ESC: begin
                        if (w_keep_key) n_kept = r_kept + 8'd1;
                        n_mode = MODE_KEY;
                    end
                    MODE_COLON: begin
                        if (i_byte == CH_COLON) n_mode = MODE_VALUE;
                        else if (!w_ws) n_mode = MODE_IDLE;
                    end
                    MODE_VALUE: begin
                        if (!w_ws) begin
                            n_kept = 8'd0;
                            if (i_byte == CH_QUOTE) n_mode = MODE_VSTR;
                            else if (i_byte == CH_COMMA) n_mode = MODE_KEYQ;
                            else if (i_byte == CH_RBRACE) n_mode = MODE_IDLE;
                            else begin
                                // first raw value byte counts when the limit is nonzero
                                n_kept = {7'd0, (r_value_limit != 8'd0)};
                                n_mode = MODE_VRAW;
                            end
                        end
                    end
                    MODE_VSTR: begin
                        if (i_byte == CH_QUOTE) n_mode = MODE_AFTER;
                        else if (i_byte == CH_BSLASH) n_mode = MODE_VSTR_ESC;
                        else if (w_keep_val) n_kept = r_kept + 8'd1;
                    end
                    MODE_VSTR_ESC: begin
                        if (w_keep_val) n_kept = r_kept + 8'd1;
                        n_mode = MODE_VSTR;
                    end
                    MODE_VRAW: begin
                        if (i_byte == CH_COMMA) n_mode = MODE_KEYQ;
                        else if (i_byte == CH_RBRACE) n_mode = MODE_IDLE;
                        else if (w_ws) n_mode = MODE_AFTER;
                        else if (w_keep_val) n_kept = r_kept + 8'd1;
                    end
                    MODE_AFTER: begin
                        if (i_byte == CH_COMMA) n_mode = MODE_KEYQ;
                        else if (i_byte == CH_RBRACE) n_mode = MODE_IDLE;
                        else if (!w_ws) n_mode = MODE_IDLE;
                    end
                    default: n_mode = MODE_IDLE;
                endcase
            end
        end
    end

    // queued results
    always_comb begin
        o_push        = 1'b0;
        o_entry.kind  = KIND_ERROR;
        o_entry.data  = 8'd0;
        o_entry.two   = 1'b0;
        if (w_accept && (r_mode != MODE_IDLE)) begin
            if (i_byte == CH_NUL) begin
                o_push = 1'b1;
            end else begin
                unique case (r_mode)
                    MODE_OPEN: begin
                        o_push = (i_byte != CH_LBRACE) && !w_ws;
                    end
                    MODE_FIRST, MODE_KEYQ: begin
                        if (!w_ws && (i_byte != CH_QUOTE)) begin
                            o_push = 1'b1;
                            if ((i_byte == CH_RBRACE) && (r_mode == MODE_FIRST))
                                o_entry.kind = KIND_DONE;
                        end
                    end
                    MODE_KEY: begin
                        if (i_byte == CH_QUOTE) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_KEY_END;
                        end else if (i_byte != CH_BSLASH) begin
                            o_push       = w_keep_key;
                            o_entry.kind = KIND_KEY_BYTE;
                            o_entry.data = i_byte;
                        end
                    end
                    MODE_KEY_ESC: begin
                        o_push       = w_keep_key;
                        o_entry.kind = KIND_KEY_BYTE;
                        o_entry.data = w_unesc;
                    end
                    MODE_COLON: begin
                        o_push = (i_byte != CH_COLON) && !w_ws;
                    end
                    MODE_VALUE: begin
                        if (i_byte == CH_COMMA) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_PAIR_END;
                        end else if (i_byte == CH_RBRACE) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_PAIR_END;
                            o_entry.two  = 1'b1;
                        end else if (!w_ws && (i_byte != CH_QUOTE)) begin
                            o_push       = (r_value_limit != 8'd0);
                            o_entry.kind = KIND_VAL_BYTE;
                            o_entry.data = i_byte;
                        end
                    end
                    MODE_VSTR: begin
                        if (i_byte == CH_QUOTE) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_PAIR_END;
                        end else if (i_byte != CH_BSLASH) begin
                            o_push       = w_keep_val;
                            o_entry.kind = KIND_VAL_BYTE;
                            o_entry.data = i_byte;
                        end
                    end
                    MODE_VSTR_ESC: begin
                        o_push       = w_keep_val;
                        o_entry.kind = KIND_VAL_BYTE;
                        o_entry.data = w_unesc;
                    end
                    MODE_VRAW: begin
                        if ((i_byte == CH_COMMA) || w_ws) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_PAIR_END;
                        end else if (i_byte == CH_RBRACE) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_PAIR_END;
                            o_entry.two  = 1'b1;
                        end else begin
                            o_push       = w_keep_val;
                            o_entry.kind = KIND_VAL_BYTE;
                            o_entry.data = i_byte;
                        end
                    end
                    MODE_AFTER: begin
                        if (i_byte == CH_RBRACE) begin
                            o_push       = 1'b1;
                            o_entry.kind = KIND_DONE;
                        end else if ((i_byte != CH_COMMA) && !w_ws) begin
                            o_push = 1'b1;
                        end
                    end
                    default: o_push = 1'b1;
                endcase
            end
        end
    end

endmodule

// File: hw/rtl/jfp_fifo.sv
// jfp_fifo: short result queue between the parse front end and the output back end
// depends on jfp_pkg for the entry type
module jfp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jfp_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output jfp_pkg::t_entry o_head
);
    import jfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_entry;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) r_count <= r_count + CNT_W'(1);
            else if (w_rd && !w_wr) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

// File: hw/rtl/jfp_back.sv
// jfp_back: drains the result queue, splitting a pair end plus done into two words
// depends on jfp_pkg for the entry and kind types
module jfp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  jfp_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output jfp_pkg::t_kind  o_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);
    import jfp_pkg::*;

    logic r_second, n_second;
    logic w_take;

    assign o_valid = !i_empty;
    assign w_take  = o_valid && i_ready;

    // second word of a two-word entry
    always_comb begin
        n_second = r_second;
        if (w_take) n_second = i_head.two && !r_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_second <= 1'b0;
        else          r_second <= n_second;
    end

    // output word select and queue pop
    always_comb begin
        o_kind        = r_second ? KIND_DONE : i_head.kind;
        o_out_byte    = r_second ? 8'd0 : i_head.data;
        o_last_of_run = r_second || !i_head.two;
        o_pop         = w_take && o_last_of_run;
    end

endmodule

// File: hw/rtl/json_flat_object_parser_top.sv
// json_flat_object_parser_top: byte-serial flat json object parser
// depends on jfp_pkg, jfp_in_if, jfp_out_if, jfp_front, jfp_fifo, jfp_back
//
//  channel   dir  handshake            word
//  i_in      in   valid/ready          in_byte
//  o_out     out  valid/ready          kind, out_byte, last_of_run
//  i_cfg_*   in   write enable only    index, data (key/value keep limits)
//
// one text byte is taken every cycle while the result queue has room
// a pair end followed by object done leaves as two words, the pair end first
// results are written into the result queue and reach o_out from its head; queue depth QUEUE_DEPTH entries
// synchronous active-low reset; the limits reset to 31 and 63
// an output stall backs up the queue, then drops i_in.ready
module json_flat_object_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jfp_in_if.sink      i_in,
    jfp_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [jfp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import jfp_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    t_entry w_entry;
    t_entry w_head;

    // parse front end
    jfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_byte      (i_in.in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    // result queue
    jfp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // output back end
    jfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_kind        (o_out.kind),
        .o_out_byte    (o_out.out_byte),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule
